// ----- design/gnmc_pkg.sv -----
// Shared types and constants of the grid neighbour match counter.
`timescale 1ns / 1ps

package gnmc_pkg;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_SIZE_W  = 11;
    localparam int CFG_VALUE_W = 16;
    localparam int COUNT_W     = 21;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_ROWS       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_COLS       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_VALUE    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEIGHBOUR_VALUE = 2'd3;

    typedef struct packed {
        logic pend;
        logic nbr;
    } t_row_flags;

    typedef struct packed {
        logic first_row;
        logic last_col;
        logic last_cell;
    } t_pos_flags;

endpackage

// ----- design/gnmc_cell_if.sv -----
// Input channel carrying one grid cell per transfer.
`timescale 1ns / 1ps

interface gnmc_cell_if #(
    parameter int VALUE_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] cell_value;

    modport source (output valid, output cell_value, input ready);
    modport sink (input valid, input cell_value, output ready);
endinterface

// ----- design/gnmc_result_if.sv -----
// Output channel carrying the running count and the end-of-grid flag.
`timescale 1ns / 1ps

interface gnmc_result_if;
    logic                           valid;
    logic                           ready;
    logic [gnmc_pkg::COUNT_W-1:0]   match_count;
    logic                           grid_done;

    modport source (output valid, output match_count, output grid_done, input ready);
    modport sink (input valid, input match_count, input grid_done, output ready);
endinterface

// ----- design/gnmc_ram.sv -----
// Generic single-write, single-read memory with registered read data.
`timescale 1ns / 1ps

module gnmc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/gnmc_pos.sv -----
// Raster position counters and grid size clamping.
`timescale 1ns / 1ps

module gnmc_pos #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_advance,
    input  logic [gnmc_pkg::CFG_SIZE_W-1:0]   i_grid_rows,
    input  logic [gnmc_pkg::CFG_SIZE_W-1:0]   i_grid_cols,
    output logic [$clog2(MAX_COLS)-1:0]       o_col,
    output gnmc_pkg::t_pos_flags              o_flags
);
    localparam int CW  = $clog2(MAX_COLS);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CCW = $clog2(MAX_COLS + 1);
    localparam int RCW = $clog2(MAX_ROWS + 1);

    logic [CW-1:0]  r_col;
    logic [RW-1:0]  r_row;
    logic [CCW-1:0] cols_eff;
    logic [RCW-1:0] rows_eff;
    logic           last_col;
    logic           last_row;

    always_comb begin
        if (i_grid_cols == '0) begin
            cols_eff = CCW'(1);
        end else if (32'(i_grid_cols) > MAX_COLS) begin
            cols_eff = CCW'(MAX_COLS);
        end else begin
            cols_eff = CCW'(i_grid_cols);
        end
        if (i_grid_rows == '0) begin
            rows_eff = RCW'(1);
        end else if (32'(i_grid_rows) > MAX_ROWS) begin
            rows_eff = RCW'(MAX_ROWS);
        end else begin
            rows_eff = RCW'(i_grid_rows);
        end
    end

    assign last_col = (CCW'(r_col) + CCW'(1)) >= cols_eff;
    assign last_row = (RCW'(r_row) + RCW'(1)) >= rows_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_advance) begin
            if (last_col && last_row) begin
                r_col <= '0;
                r_row <= '0;
            end else if (last_col) begin
                r_col <= '0;
                r_row <= r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    assign o_col             = r_col;
    assign o_flags.first_row = (r_row == '0);
    assign o_flags.last_col  = last_col;
    assign o_flags.last_cell = last_col && last_row;
endmodule

// ----- design/gnmc_core.sv -----
// Cell evaluation: neighbour flags, deferred row-flag writes and the running count.
`timescale 1ns / 1ps

module gnmc_core #(
    parameter int MAX_COLS   = 1024,
    parameter int VALUE_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_fire,
    input  logic [VALUE_BITS-1:0]              i_value,
    input  logic [$clog2(MAX_COLS)-1:0]        i_col,
    input  gnmc_pkg::t_pos_flags               i_flags,
    input  gnmc_pkg::t_row_flags               i_mem_rdata,
    input  logic                               i_fwd_valid,
    input  gnmc_pkg::t_row_flags               i_fwd_data,
    input  logic [gnmc_pkg::CFG_VALUE_W-1:0]   i_target,
    input  logic [gnmc_pkg::CFG_VALUE_W-1:0]   i_neighbour,
    output logic                               o_wr_en,
    output logic [$clog2(MAX_COLS)-1:0]        o_wr_addr,
    output gnmc_pkg::t_row_flags               o_wr_data,
    output logic [gnmc_pkg::COUNT_W-1:0]       o_count
);
    localparam int CW = $clog2(MAX_COLS);

    gnmc_pkg::t_row_flags         r_left;
    logic                         r_tail_valid;
    logic [CW-1:0]                r_tail_addr;
    gnmc_pkg::t_row_flags         r_tail_data;
    logic [gnmc_pkg::COUNT_W-1:0] r_count;

    logic                         is_t;
    logic                         is_n;
    logic                         first_col;
    gnmc_pkg::t_row_flags         above;
    gnmc_pkg::t_row_flags         left;
    gnmc_pkg::t_row_flags         mine;
    logic                         has_nbr;
    logic [1:0]                   inc;
    logic [gnmc_pkg::COUNT_W:0]   sum;

    assign is_t      = (i_value == VALUE_BITS'(i_target));
    assign is_n      = (i_value == VALUE_BITS'(i_neighbour));
    assign first_col = (i_col == '0);

    always_comb begin
        if (i_flags.first_row) begin
            above = '0;
        end else if (r_tail_valid && (r_tail_addr == i_col)) begin
            above = r_tail_data;
        end else if (i_fwd_valid) begin
            above = i_fwd_data;
        end else begin
            above = i_mem_rdata;
        end
        left      = first_col ? '0 : r_left;
        has_nbr   = above.nbr || left.nbr;
        mine.nbr  = is_n;
        mine.pend = is_t && !has_nbr;
        inc = 2'(is_n && above.pend) + 2'(is_n && left.pend) + 2'(is_t && has_nbr);
        sum = {1'b0, r_count} + (gnmc_pkg::COUNT_W + 1)'(inc);
        if (sum > {1'b0, gnmc_pkg::COUNT_MAX}) begin
            o_count = gnmc_pkg::COUNT_MAX;
        end else begin
            o_count = sum[gnmc_pkg::COUNT_W-1:0];
        end
    end

    // left cell becomes final once its right neighbour is seen
    always_comb begin
        if (!first_col) begin
            o_wr_en        = i_fire;
            o_wr_addr      = i_col - CW'(1);
            o_wr_data.nbr  = r_left.nbr;
            o_wr_data.pend = r_left.pend && !is_n;
        end else begin
            o_wr_en   = i_fire && r_tail_valid;
            o_wr_addr = r_tail_addr;
            o_wr_data = r_tail_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left       <= '0;
            r_tail_valid <= 1'b0;
            r_count      <= '0;
        end else if (i_fire) begin
            r_left  <= i_flags.last_col ? '0 : mine;
            r_count <= i_flags.last_cell ? '0 : o_count;
            if (i_flags.last_col) begin
                r_tail_valid <= 1'b1;
            end else if (first_col) begin
                r_tail_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && i_flags.last_col) begin
            r_tail_addr <= i_col;
            r_tail_data <= mine;
        end
    end
endmodule

// ----- design/grid_neighbour_match_count.sv -----
// Top level of the grid neighbour match counter.
`timescale 1ns / 1ps

// Counts grid cells equal to target_value that have a 4-connected neighbour equal
// to neighbour_value, with cells streamed in raster order. Each transferred cell
// yields one result carrying the running count of the current grid and a flag on
// its last cell; the count restarts with the next grid. Throughput is one cell per
// clock while the output is not stalled: the row-flag memory is read when a cell is
// transferred, and a cell's flags are written back when the cell to its right is
// evaluated (the last cell of a row when the next row starts), with forwarding of
// the write in flight and of the deferred end-of-row write, so no cell waits on
// another. A result passes the evaluation-stage register and then the output
// register after its cell is transferred. Configuration may be written only while
// no cell is in flight. The row-flag memory needs no clearing after reset.
module grid_neighbour_match_count #(
    parameter int MAX_COLS   = 1024,
    parameter int MAX_ROWS   = 1024,
    parameter int VALUE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gnmc_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [gnmc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    gnmc_cell_if.sink                           i_cell,
    gnmc_result_if.source                       o_result
);
    localparam int CW = $clog2(MAX_COLS);

    logic [gnmc_pkg::CFG_SIZE_W-1:0]  r_grid_rows;
    logic [gnmc_pkg::CFG_SIZE_W-1:0]  r_grid_cols;
    logic [gnmc_pkg::CFG_VALUE_W-1:0] r_target_value;
    logic [gnmc_pkg::CFG_VALUE_W-1:0] r_neighbour_value;

    logic                             r_s1_valid;
    logic [VALUE_BITS-1:0]            r_s1_value;
    logic [CW-1:0]                    r_s1_col;
    gnmc_pkg::t_pos_flags             r_s1_flags;
    logic                             r_fwd_valid;
    gnmc_pkg::t_row_flags             r_fwd_data;

    logic                             r_out_valid;
    logic [gnmc_pkg::COUNT_W-1:0]     r_out_count;
    logic                             r_out_done;

    logic                             in_fire;
    logic                             fire1;
    logic [CW-1:0]                    w_col;
    gnmc_pkg::t_pos_flags             w_pos_flags;
    logic                             w_wr_en;
    logic [CW-1:0]                    w_wr_addr;
    gnmc_pkg::t_row_flags             w_wr_data;
    logic [$bits(gnmc_pkg::t_row_flags)-1:0] w_rdata;
    logic [gnmc_pkg::COUNT_W-1:0]     w_count;

    assign fire1         = r_s1_valid && (!r_out_valid || o_result.ready);
    assign i_cell.ready  = !r_s1_valid || fire1;
    assign in_fire       = i_cell.valid && i_cell.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows       <= gnmc_pkg::CFG_SIZE_W'(1);
            r_grid_cols       <= gnmc_pkg::CFG_SIZE_W'(1);
            r_target_value    <= '0;
            r_neighbour_value <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gnmc_pkg::CFG_GRID_ROWS: begin
                    r_grid_rows <= i_cfg_data[gnmc_pkg::CFG_SIZE_W-1:0];
                end
                gnmc_pkg::CFG_GRID_COLS: begin
                    r_grid_cols <= i_cfg_data[gnmc_pkg::CFG_SIZE_W-1:0];
                end
                gnmc_pkg::CFG_TARGET_VALUE: begin
                    r_target_value <= i_cfg_data[gnmc_pkg::CFG_VALUE_W-1:0];
                end
                gnmc_pkg::CFG_NEIGHBOUR_VALUE: begin
                    r_neighbour_value <= i_cfg_data[gnmc_pkg::CFG_VALUE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    gnmc_pos #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_pos (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (in_fire),
        .i_grid_rows (r_grid_rows),
        .i_grid_cols (r_grid_cols),
        .o_col       (w_col),
        .o_flags     (w_pos_flags)
    );

    gnmc_ram #(
        .WIDTH ($bits(gnmc_pkg::t_row_flags)),
        .DEPTH (MAX_COLS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr_en),
        .i_waddr (w_wr_addr),
        .i_wdata (w_wr_data),
        .i_re    (in_fire),
        .i_raddr (w_col),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (fire1) begin
            r_s1_valid <= 1'b0;
        end
    end

    // register the transferred cell and capture a write that lands on the entry being read in the same cycle
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_value  <= i_cell.cell_value;
            r_s1_col    <= w_col;
            r_s1_flags  <= w_pos_flags;
            r_fwd_valid <= w_wr_en && (w_wr_addr == w_col);
            r_fwd_data  <= w_wr_data;
        end
    end

    gnmc_core #(
        .MAX_COLS   (MAX_COLS),
        .VALUE_BITS (VALUE_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire1),
        .i_value     (r_s1_value),
        .i_col       (r_s1_col),
        .i_flags     (r_s1_flags),
        .i_mem_rdata (gnmc_pkg::t_row_flags'(w_rdata)),
        .i_fwd_valid (r_fwd_valid),
        .i_fwd_data  (r_fwd_data),
        .i_target    (r_target_value),
        .i_neighbour (r_neighbour_value),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_count     (w_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire1) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire1) begin
            r_out_count <= w_count;
            r_out_done  <= r_s1_flags.last_cell;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.match_count = r_out_count;
    assign o_result.grid_done   = r_out_done;

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_s1_valid)
        else $error("transferred cell did not reach the evaluation stage");

    a_write_on_retire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> fire1)
        else $error("row-flag memory written without a retiring cell");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !fire1) |=> (r_s1_valid && $stable(r_s1_col) && $stable(r_s1_value)))
        else $error("stalled cell lost or changed in the evaluation stage");
endmodule
